// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token kind codes, character codes and helper functions shared by
// the tokenizer front end, run queue and token serializer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int KW_BITS = 40;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int MAX_TOK = 3;

    localparam logic [4:0] K_IDENT = 5'd0;
    localparam logic [4:0] K_IF    = 5'd1;
    localparam logic [4:0] K_ELSE  = 5'd2;
    localparam logic [4:0] K_LET   = 5'd3;
    localparam logic [4:0] K_FN    = 5'd4;
    localparam logic [4:0] K_TRUE  = 5'd5;
    localparam logic [4:0] K_FALSE = 5'd6;
    localparam logic [4:0] K_SEMI  = 5'd7;
    localparam logic [4:0] K_LPAR  = 5'd8;
    localparam logic [4:0] K_RPAR  = 5'd9;
    localparam logic [4:0] K_LBRC  = 5'd10;
    localparam logic [4:0] K_RBRC  = 5'd11;
    localparam logic [4:0] K_LBRK  = 5'd12;
    localparam logic [4:0] K_RBRK  = 5'd13;
    localparam logic [4:0] K_PLUS  = 5'd14;
    localparam logic [4:0] K_MINUS = 5'd15;
    localparam logic [4:0] K_STAR  = 5'd16;
    localparam logic [4:0] K_PCT   = 5'd17;
    localparam logic [4:0] K_SLASH = 5'd18;
    localparam logic [4:0] K_ASSIGN= 5'd19;
    localparam logic [4:0] K_EQEQ  = 5'd20;
    localparam logic [4:0] K_NOT   = 5'd21;
    localparam logic [4:0] K_NEQ   = 5'd22;
    localparam logic [4:0] K_AMP   = 5'd23;
    localparam logic [4:0] K_ANDAND= 5'd24;
    localparam logic [4:0] K_BAR   = 5'd25;
    localparam logic [4:0] K_OROR  = 5'd26;
    localparam logic [4:0] K_LT    = 5'd27;
    localparam logic [4:0] K_LE    = 5'd28;
    localparam logic [4:0] K_GT    = 5'd29;
    localparam logic [4:0] K_GE    = 5'd30;
    localparam logic [4:0] K_NONE  = 5'd0;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // keyword spellings, first character in the low byte
    localparam logic [KW_BITS-1:0] KW_IF    = 40'h00_0000_6669;
    localparam logic [KW_BITS-1:0] KW_ELSE  = 40'h00_6573_6C65;
    localparam logic [KW_BITS-1:0] KW_LET   = 40'h00_0074_656C;
    localparam logic [KW_BITS-1:0] KW_FN    = 40'h00_0000_6E66;
    localparam logic [KW_BITS-1:0] KW_TRUE  = 40'h00_6575_7254;
    localparam logic [KW_BITS-1:0] KW_FALSE = 40'h65_736C_6146;

    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] col;
        logic [15:0] line;
        logic [4:0]  kind;
    } t_tok;

    typedef struct packed {
        logic [1:0]             cnt;
        t_tok [MAX_TOK-1:0]     tok;
    } t_run;

    typedef struct packed {
        logic empty;
        t_run head;
    } t_qhead;

    function automatic logic [4:0] sep_kind(input logic [7:0] a, input logic [7:0] nx);
        logic [4:0] k;
        unique case (a)
            CH_SEMI:  k = K_SEMI;
            CH_LPAR:  k = K_LPAR;
            CH_RPAR:  k = K_RPAR;
            CH_LBRC:  k = K_LBRC;
            CH_RBRC:  k = K_RBRC;
            CH_LBRK:  k = K_LBRK;
            CH_RBRK:  k = K_RBRK;
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            CH_STAR:  k = K_STAR;
            CH_PCT:   k = K_PCT;
            CH_SLASH: k = K_SLASH;
            CH_EQ:    k = (nx == CH_EQ)  ? K_EQEQ   : K_ASSIGN;
            CH_BANG:  k = (nx == CH_EQ)  ? K_NEQ    : K_NOT;
            CH_AMP:   k = (nx == CH_AMP) ? K_ANDAND : K_AMP;
            CH_BAR:   k = (nx == CH_BAR) ? K_OROR   : K_BAR;
            CH_LT:    k = (nx == CH_EQ)  ? K_LE     : K_LT;
            CH_GT:    k = (nx == CH_EQ)  ? K_GE     : K_GT;
            default:  k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_pair(input logic [4:0] k);
        return (k == K_EQEQ) || (k == K_NEQ) || (k == K_ANDAND) ||
               (k == K_OROR) || (k == K_LE) || (k == K_GE);
    endfunction

    function automatic logic [4:0] kw_kind(input logic [7:0] wc,
                                           input logic [KW_BITS-1:0] p);
        logic [4:0] k;
        priority if (wc == 8'd2 && p == KW_IF)    k = K_IF;
        else if     (wc == 8'd4 && p == KW_ELSE)  k = K_ELSE;
        else if     (wc == 8'd3 && p == KW_LET)   k = K_LET;
        else if     (wc == 8'd2 && p == KW_FN)    k = K_FN;
        else if     (wc == 8'd4 && p == KW_TRUE)  k = K_TRUE;
        else if     (wc == 8'd5 && p == KW_FALSE) k = K_FALSE;
        else                                      k = K_IDENT;
        return k;
    endfunction

endpackage

// ===== rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical tokenizer: bytes in, word/keyword/operator tokens out.
// Accepts one byte per cycle while the 4-run queue has room; the tokens that
// an accepted byte completes are registered in the queue as one run and leave
// one token per cycle while the output is ready (at most 3 per byte).
// A word's tokens wait for the byte that ends it (one byte of lookahead).
// Synchronous active-low reset clears lookahead, counters and queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int MAX_WORD_LEN  = 255,
    parameter int KEYWORD_CHARS = 5,
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [4:0] token_kind, [20:5] line_number,
                                     // [36:21] column_number, [44:37] word_length
    output logic        o_m_tlast    // last_of_run
);
    import stt_pkg::*;

    logic   full, push, pop;
    t_run   run;
    t_qhead head;
    t_tok   tok;

    stt_front #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_run   (run)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_tok   (tok),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, tok.len, tok.col, tok.line, tok.kind};

endmodule

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Lookahead, line/column/word counters and classification. Turns each accepted
// byte into a run of up to three tokens and pushes the run when it is not empty.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int MAX_WORD_LEN  = 255,
    parameter int KEYWORD_CHARS = 5,
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output stt_pkg::t_run o_run
);
    import stt_pkg::*;

    localparam int POS_W  = (POSITION_BITS < 16) ? POSITION_BITS : 16;
    localparam int PREF_W = 8 * KEYWORD_CHARS;
    localparam logic [7:0] WORD_CAP = 8'((MAX_WORD_LEN < 255) ? MAX_WORD_LEN : 255);
    localparam logic [7:0] KW_LIM   = 8'(KEYWORD_CHARS);

    logic [7:0]       r_la;
    logic             r_la_valid;
    logic             r_skip;
    logic [POS_W-1:0] r_line;
    logic [POS_W-1:0] r_col;
    logic [7:0]       r_wc;
    logic [PREF_W-1:0] r_pref;

    logic [POS_W-1:0]  line, col;
    logic [7:0]        wc;
    logic [PREF_W-1:0] pref;
    logic              skip;
    logic [1:0]        n;
    t_run              run;
    logic [4:0]        kind_a, kind_b;
    logic              accept;

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic t_tok mk_tok(input logic [4:0] k, input logic [7:0] len,
                                    input logic [POS_W-1:0] l,
                                    input logic [POS_W-1:0] c);
        t_tok t;
        t.kind = k;
        t.len  = len;
        t.line = 16'(l);
        t.col  = 16'(c);
        return t;
    endfunction

    function automatic logic [PREF_W-1:0] add_pref(input logic [PREF_W-1:0] p,
                                                   input logic [7:0] w,
                                                   input logic [7:0] c);
        logic [PREF_W-1:0] q;
        q = p;
        for (int j = 0; j < KEYWORD_CHARS; j++) begin
            if (w == 8'(j) && w < KW_LIM) begin
                q[8*j +: 8] = c;
            end
        end
        return q;
    endfunction

    always_comb begin
        line   = r_line;
        col    = r_col;
        wc     = r_wc;
        pref   = r_pref;
        skip   = r_skip;
        n      = 2'd0;
        run    = '0;
        kind_a = sep_kind(r_la, i_byte);
        kind_b = sep_kind(i_byte, CH_SPACE);

        if (r_la_valid) begin
            if (r_skip) begin
                skip = 1'b0;
            end else begin
                if (kind_a != K_NONE || r_la == CH_SPACE || r_la == CH_NL) begin
                    if (wc != 8'd0) begin
                        run.tok[n] = mk_tok(kw_kind(wc, pref[KW_BITS-1:0]), wc, line, col);
                        n    = n + 2'd1;
                        wc   = '0;
                        pref = '0;
                    end
                end
                if (kind_a != K_NONE) begin
                    if (is_pair(kind_a)) begin
                        col  = pos_inc(col);
                        skip = 1'b1;
                    end
                    run.tok[n] = mk_tok(kind_a, is_pair(kind_a) ? 8'd2 : 8'd1, line, col);
                    n = n + 2'd1;
                end else if (r_la == CH_NL) begin
                    line = pos_inc(line);
                    col  = '0;
                end else if (r_la != CH_SPACE) begin
                    pref = add_pref(pref, wc, r_la);
                    wc   = (wc < WORD_CAP) ? wc + 8'd1 : wc;
                end
                col = pos_inc(col);
            end
        end

        if (i_last && !skip) begin
            if (kind_b == K_NONE && i_byte != CH_SPACE && i_byte != CH_NL) begin
                pref = add_pref(pref, wc, i_byte);
                wc   = (wc < WORD_CAP) ? wc + 8'd1 : wc;
            end
            if (wc != 8'd0) begin
                run.tok[n] = mk_tok(kw_kind(wc, pref[KW_BITS-1:0]), wc, line, col);
                n = n + 2'd1;
            end
            if (kind_b != K_NONE) begin
                run.tok[n] = mk_tok(kind_b, 8'd1, line, col);
                n = n + 2'd1;
            end
        end
        run.cnt = n;
    end

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign o_push  = accept && (n != 2'd0);
    assign o_run   = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la       <= '0;
            r_la_valid <= 1'b0;
            r_skip     <= 1'b0;
            r_line     <= '0;
            r_col      <= '0;
            r_wc       <= '0;
            r_pref     <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_la       <= '0;
                r_la_valid <= 1'b0;
                r_skip     <= 1'b0;
                r_line     <= '0;
                r_col      <= '0;
                r_wc       <= '0;
                r_pref     <= '0;
            end else begin
                r_la       <= i_byte;
                r_la_valid <= 1'b1;
                r_skip     <= skip;
                r_line     <= line;
                r_col      <= col;
                r_wc       <= wc;
                r_pref     <= pref;
            end
        end
    end

endmodule

// ===== rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of token runs between the front end and the serializer.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_run   i_run,
    output logic            o_full,
    input  logic            i_pop,
    output stt_pkg::t_qhead o_head
);
    import stt_pkg::*;

    t_run              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              pop;

    assign o_full      = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.head  = r_mem[r_rd];
    assign pop          = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Token serializer: walks the head run one token per cycle, while the output
// is ready, onto the output stream and marks the run's final token.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stt_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output stt_pkg::t_tok   o_tok,
    output logic            o_last
);
    import stt_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       fire;

    assign o_valid = !i_head.empty;
    assign o_tok   = i_head.head.tok[r_idx];
    assign o_last  = (r_idx == 2'(i_head.head.cnt - 2'd1));
    assign fire    = o_valid && i_ready;
    assign o_pop   = fire && o_last;

    always_comb begin
        n_idx = r_idx;
        if (fire) begin
            n_idx = o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule
